FILE: design/pagerank_push_iteration_core_assert.svh
// assertion macros used by the checker module
`ifndef PAGERANK_PUSH_ITERATION_CORE_ASSERT_SVH
`define PAGERANK_PUSH_ITERATION_CORE_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define PR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define PR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: design/prp_pkg.sv
// ----------------------------------------------------------------------------
// prp_pkg
// types, command and register codes shared by the pagerank push core
// ----------------------------------------------------------------------------
`default_nettype none
package prp_pkg;
  localparam int unsigned MaxNodes = 2048;
  localparam int unsigned IdxW = $clog2(MaxNodes);
  localparam int unsigned CntW = IdxW + 1;

  localparam logic [2:0] KindLoad   = 3'd0;
  localparam logic [2:0] KindStart  = 3'd1;
  localparam logic [2:0] KindEdge   = 3'd2;
  localparam logic [2:0] KindFinish = 3'd3;
  localparam logic [2:0] KindRead   = 3'd4;

  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatIndex  = 2'd1;
  localparam logic [1:0] StatDegree = 2'd2;

  localparam logic [1:0] RegAlpha = 2'd0;
  localparam logic [1:0] RegBase  = 2'd1;
  localparam logic [1:0] RegEps   = 2'd2;
  localparam logic [1:0] RegNodes = 2'd3;

  // divider request
  typedef struct packed {
    logic        start;
    logic [47:0] dividend;
    logic [11:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

FILE: design/prp_divider.sv
// ----------------------------------------------------------------------------
// prp_divider
// restoring radix-2 divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module prp_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire prp_pkg::div_req_t req_i,
  output prp_pkg::div_rsp_t      rsp_o
);
  import prp_pkg::*;

  logic [47:0] quo_q, quo_d;
  logic [12:0] rem_q, rem_d;
  logic [11:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [12:0] trial;
  logic [13:0] sub;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; dvs_d = dvs_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[11:0], quo_q[47]};
    sub = {1'b0, trial} - {2'b0, dvs_q};
    if (req_i.start) begin
      quo_d = req_i.dividend; rem_d = '0; dvs_d = req_i.divisor;
      cnt_d = 6'd0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!sub[13]) begin
        rem_d = sub[12:0]; quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = trial; quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd47) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quotient = quo_q;
endmodule
`default_nettype wire

FILE: design/pagerank_push_iteration_core.sv
// pagerank push core, sequencer around two score memories and a divider
// request to result: load writes the old bank, read waits on a bank read, edge multiplies,
// divides (48-step divider) and adds, rejected or unknown just answer; start: one new-bank
// write per cycle; finish: one multiply per vertex in use; one request at a time
// result registered, next request taken the cycle after the result is accepted
// reset: registers take reset values, then a clearing pass zeroes all entries of both banks
// ----------------------------------------------------------------------------
// pagerank_push_iteration_core
// holds old and new score banks and runs one push pass command at a time
// ----------------------------------------------------------------------------
`default_nettype none
module pagerank_push_iteration_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // kind[2:0]
  input  wire logic [2:0]   s_axis_tuser,
  // vertex_index[10:0], dest_index[21:11], degree[33:22], score_value[65:34],
  // zero fill
  input  wire logic [71:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // score[31:0], diff_sum[95:32], converged[96], status[98:97], zero fill
  output logic [103:0]      m_axis_tdata,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [63:0]  cfg_data_i
);
  import prp_pkg::*;

  localparam logic [3:0] StClear = 4'd0, StIdle = 4'd1, StRd = 4'd2, StRdW = 4'd3,
                         StMul = 4'd4, StDiv = 4'd5, StAdd = 4'd6, StFill = 4'd7,
                         StFinRd = 4'd8, StFinW = 4'd9, StFinSq = 4'd10,
                         StFinAcc = 4'd11, StOut = 4'd12, StDivW = 4'd13;

  logic [3:0]  st_q, st_d;
  logic [15:0] alpha_q;
  logic [31:0] base_q;
  logic [63:0] eps_q;
  logic [11:0] nodes_q;

  logic [31:0] old_mem [MaxNodes];
  logic [31:0] new_mem [MaxNodes];
  logic [31:0] old_rd_q, new_rd_q;
  logic [IdxW-1:0] old_ra, new_ra, old_wa, new_wa;
  logic [31:0] old_wd, new_wd;
  logic        old_we, new_we;

  logic [2:0]  kind_q;
  logic [IdxW-1:0] vidx_q, didx_q;
  logic [11:0] deg_q;
  logic [31:0] sval_q;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic [47:0] prod_q, prod_d;
  logic [47:0] prod_full;
  logic [63:0] sum_q, sum_d, sq_q, sq_d;
  logic [31:0] dif_q, dif_d;
  logic [103:0] out_q, out_d;
  logic        ov_q, ov_d;
  logic [11:0] count;
  logic [31:0] contrib;
  logic [32:0] nsum;
  logic [64:0] acc;
  logic [71:0] cap;
  logic        bad;
  div_req_t    dreq;
  div_rsp_t    drsp;

  prp_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign count = (nodes_q > 12'(MaxNodes)) ? 12'(MaxNodes) : nodes_q;
  assign cap = s_axis_tdata;
  assign s_axis_tready = (st_q == StIdle) && !ov_q;
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = out_q;
  assign contrib = (drsp.quotient[47:32] != '0) ? 32'hFFFF_FFFF : drsp.quotient[31:0];
  assign nsum = {1'b0, new_rd_q} + {1'b0, contrib};
  assign acc = {1'b0, sum_q} + {1'b0, sq_q};
  assign prod_full = alpha_q * old_rd_q;

  always_ff @(posedge clk_i) begin
    if (old_we) old_mem[old_wa] <= old_wd;
    old_rd_q <= old_mem[old_ra];
  end
  always_ff @(posedge clk_i) begin
    if (new_we) new_mem[new_wa] <= new_wd;
    new_rd_q <= new_mem[new_ra];
  end

  always_comb begin
    st_d = st_q; ptr_d = ptr_q; prod_d = prod_q; sum_d = sum_q; sq_d = sq_q;
    dif_d = dif_q; out_d = out_q; ov_d = ov_q;
    old_we = 1'b0; new_we = 1'b0;
    old_wa = ptr_q[IdxW-1:0]; new_wa = ptr_q[IdxW-1:0];
    old_wd = '0; new_wd = '0;
    old_ra = vidx_q; new_ra = didx_q;
    dreq = '0; bad = 1'b0;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    unique case (st_q)
      StClear: begin
        old_we = 1'b1; new_we = 1'b1;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == CntW'(MaxNodes - 1)) st_d = StIdle;
      end
      StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          ptr_d = '0; sum_d = '0;
          st_d = StRd;
        end
      end
      StRd: begin
        out_d = '0;
        unique case (kind_q)
          KindLoad: begin
            if (12'(vidx_q) >= count) out_d[98:97] = StatIndex;
            else begin
              old_we = 1'b1; old_wa = vidx_q; old_wd = sval_q;
            end
            st_d = StOut;
          end
          KindStart: st_d = StFill;
          KindEdge: begin
            bad = (12'(vidx_q) >= count) || (12'(didx_q) >= count);
            if (bad) begin
              out_d[98:97] = StatIndex; st_d = StOut;
            end else if (deg_q == '0) begin
              out_d[98:97] = StatDegree; st_d = StOut;
            end else st_d = StMul;
          end
          KindFinish: begin
            if (count == '0) begin
              out_d[96] = (eps_q != '0); st_d = StOut;
            end else begin
              old_ra = '0; new_ra = '0; st_d = StFinW;
            end
          end
          KindRead: begin
            new_ra = vidx_q; st_d = StRdW;
          end
          default: st_d = StOut;
        endcase
      end
      StRdW: begin
        if (12'(vidx_q) >= count) out_d[98:97] = StatIndex;
        else out_d[31:0] = new_rd_q;
        st_d = StOut;
      end
      StMul: begin
        prod_d = {15'b0, prod_full[47:15]};
        st_d = StDiv;
      end
      StDiv: begin
        dreq.start = 1'b1; dreq.dividend = prod_q; dreq.divisor = deg_q;
        st_d = StDivW;
      end
      StDivW: if (drsp.done) st_d = StAdd;
      StAdd: begin
        new_we = 1'b1; new_wa = didx_q;
        new_wd = nsum[32] ? 32'hFFFF_FFFF : nsum[31:0];
        st_d = StOut;
      end
      StFill: begin
        new_we = 1'b1; new_wd = base_q;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == CntW'(MaxNodes - 1)) st_d = StOut;
      end
      StFinRd: begin
        old_ra = ptr_q[IdxW-1:0]; new_ra = ptr_q[IdxW-1:0];
        st_d = StFinW;
      end
      StFinW: begin
        dif_d = (new_rd_q > old_rd_q) ? new_rd_q - old_rd_q : old_rd_q - new_rd_q;
        old_we = 1'b1; old_wd = new_rd_q;
        st_d = StFinSq;
      end
      StFinSq: begin
        sq_d = dif_q * dif_q;
        st_d = StFinAcc;
      end
      StFinAcc: begin
        sum_d = acc[64] ? '1 : acc[63:0];
        ptr_d = ptr_q + 1'b1;
        if (12'(ptr_q) == count - 12'd1) begin
          out_d[95:32] = acc[64] ? '1 : acc[63:0];
          out_d[96] = ((acc[64] ? '1 : acc[63:0]) < eps_q);
          st_d = StOut;
        end else st_d = StFinRd;
      end
      StOut: begin
        ov_d = 1'b1; st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; ptr_q <= '0; ov_q <= 1'b0;
      alpha_q <= 16'd27853; base_q <= 32'd78643;
      eps_q <= 64'd1152921504607; nodes_q <= 12'd2048;
    end else begin
      st_q <= st_d; ptr_q <= ptr_d; ov_q <= ov_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegAlpha: alpha_q <= cfg_data_i[15:0];
          RegBase:  base_q <= cfg_data_i[31:0];
          RegEps:   eps_q <= cfg_data_i;
          RegNodes: nodes_q <= cfg_data_i[11:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d; sum_q <= sum_d; sq_q <= sq_d; dif_q <= dif_d; out_q <= out_d;
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q <= s_axis_tuser; vidx_q <= cap[10:0]; didx_q <= cap[21:11];
      deg_q <= cap[33:22]; sval_q <= cap[65:34];
    end
  end
endmodule
`default_nettype wire

FILE: design/prp_checker.sv
// ----------------------------------------------------------------------------
// prp_checker
// port-level checks on the pagerank push core, bound into the core module
// ----------------------------------------------------------------------------
`default_nettype none
`include "pagerank_push_iteration_core_assert.svh"
module prp_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [103:0] m_axis_tdata
);
  `PR_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `PR_ASSERT_IMP(a_no_req_while_out, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  `PR_ASSERT_IMP(a_status_code, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[98:97] != 2'd3)
  `PR_ASSERT_NEXT(a_out_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule

bind pagerank_push_iteration_core prp_checker u_prp_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire

FILE: verif/tb_pagerank_push_iteration_core.sv
// ----------------------------------------------------------------------------
// tb_pagerank_push_iteration_core
// self-checking bench for the push-style pagerank pass core: load, start,
// edge, finish and read requests are streamed in and every result is compared
// with an in-bench score-bank model, under random source gaps, sink stalls
// and register settings
// ----------------------------------------------------------------------------
`default_nettype none
module tb_pagerank_push_iteration_core;
  import prp_pkg::*;

  localparam int unsigned IdleLimit = 50000;
  localparam int unsigned RandItems = 1750;

  typedef struct packed {
    logic [1:0]  status;
    logic        conv;
    logic [63:0] diff;
    logic [31:0] score;
  } pass_result_t;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [2:0]    s_axis_tuser;
  logic [71:0]   s_axis_tdata;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [103:0]  m_axis_tdata;
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  logic [1:0]    cfg_index_i;
  logic [63:0]   cfg_data_i;

  pagerank_push_iteration_core uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  logic [31:0]  old_bank [MaxNodes];
  logic [31:0]  new_bank [MaxNodes];
  logic [15:0]  damping;
  logic [31:0]  teleport;
  logic [63:0]  threshold;
  logic [11:0]  vertex_total;

  pass_result_t result_q[$];
  int unsigned  err_cnt = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  burst_left = 0;
  int unsigned  gap_max = 4;
  int unsigned  rx_mode = 0;
  int unsigned  rx_cnt = 0;

  function automatic int unsigned vertices_in_use();
    return (vertex_total < MaxNodes) ? vertex_total : MaxNodes;
  endfunction

  function automatic pass_result_t run_command(logic [2:0] k, logic [10:0] v, logic [10:0] d,
                                               logic [11:0] g, logic [31:0] s);
    pass_result_t r;
    int unsigned cnt;
    longint unsigned prod, contrib, sum, sq, delta;
    r = '0;
    cnt = vertices_in_use();
    case (k)
      KindLoad: begin
        if (v >= cnt) r.status = StatIndex;
        else old_bank[v] = s;
      end
      KindStart: begin
        for (int i = 0; i < MaxNodes; i++) new_bank[i] = teleport;
      end
      KindEdge: begin
        if (v >= cnt || d >= cnt) r.status = StatIndex;
        else if (g == 0) r.status = StatDegree;
        else begin
          prod = (longint'(damping) * longint'(old_bank[v])) >> 15;
          contrib = prod / g;
          if (contrib > 64'hFFFF_FFFF) contrib = 64'hFFFF_FFFF;
          sum = longint'(new_bank[d]) + contrib;
          new_bank[d] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        end
      end
      KindFinish: begin
        for (int i = 0; i < cnt; i++) begin
          delta = 64'((new_bank[i] > old_bank[i]) ? new_bank[i] - old_bank[i]
                                                  : old_bank[i] - new_bank[i]);
          sq = delta * delta;
          sum = r.diff + sq;
          r.diff = (sum < r.diff) ? 64'hFFFF_FFFF_FFFF_FFFF : sum;
          old_bank[i] = new_bank[i];
        end
        r.conv = (r.diff < threshold);
      end
      KindRead: begin
        if (v >= cnt) r.status = StatIndex;
        else r.score = new_bank[v];
      end
      default: ;
    endcase
    return r;
  endfunction

  // sink stall patterns
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cnt <= rx_cnt + 1;
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= $urandom_range(0, 1);
        2: m_axis_tready <= ($urandom_range(0, 7) == 0);
        default: m_axis_tready <= (rx_cnt % 7) > 2;
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    pass_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        err_cnt++;
      end else begin
        want = result_q.pop_front();
        if (m_axis_tdata[31:0] !== want.score) begin
          $error("score: expected %h actual %h", want.score, m_axis_tdata[31:0]);
          err_cnt++;
        end
        if (m_axis_tdata[95:32] !== want.diff) begin
          $error("diff_sum: expected %h actual %h", want.diff, m_axis_tdata[95:32]);
          err_cnt++;
        end
        if (m_axis_tdata[96] !== want.conv) begin
          $error("converged: expected %b actual %b", want.conv, m_axis_tdata[96]);
          err_cnt++;
        end
        if (m_axis_tdata[98:97] !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, m_axis_tdata[98:97]);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on stalled progress
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("pagerank_push_iteration_core test failed");
      $finish;
    end
  end

  task automatic send_cmd(logic [2:0] k, logic [10:0] v, logic [10:0] d,
                          logic [11:0] g, logic [31:0] s);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {6'b0, s, g, d, v};
    do @(posedge clk_i); while (!s_axis_tready);
    result_q.push_back(run_command(k, v, d, g, s));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // hold the source until every result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [63:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegAlpha: damping = val[15:0];
      RegBase:  teleport = val[31:0];
      RegEps:   threshold = val;
      default:  vertex_total = val[11:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic test_basic_pass();
    send_cmd(KindRead, 11'd0, 11'd0, 12'd0, 32'd0);
    send_cmd(KindLoad, 11'd0, 11'd0, 12'd0, 32'hFFFF_FFFF);
    send_cmd(KindLoad, 11'd2047, 11'd0, 12'd0, 32'h4000_0000);
    send_cmd(KindLoad, 11'd5, 11'h7FF, 12'hFFF, 32'h1234_5678);
    send_cmd(KindStart, 11'd0, 11'd0, 12'd0, 32'd0);
    send_cmd(KindEdge, 11'd0, 11'd1, 12'd1, 32'd0);
    send_cmd(KindEdge, 11'd2047, 11'd2047, 12'd2048, 32'd0);
    send_cmd(KindEdge, 11'd5, 11'd1, 12'd0, 32'd0);
    for (int k = KindRead + 1; k < 8; k++) send_cmd(3'(k), 11'h7FF, 11'h7FF, 12'hFFF, '1);
    send_cmd(KindFinish, 11'd0, 11'd0, 12'd0, 32'd0);
    send_cmd(KindRead, 11'd1, 11'd0, 12'd0, 32'd0);
    send_cmd(KindRead, 11'd2047, 11'd0, 12'd0, 32'd0);
    drain();
  endtask

  task automatic test_bad_index();
    cfg_write(RegNodes, 64'd4);
    send_cmd(KindLoad, 11'd4, 11'd0, 12'd0, 32'd9);
    send_cmd(KindEdge, 11'd4, 11'd0, 12'd1, 32'd0);
    send_cmd(KindEdge, 11'd0, 11'd4, 12'd0, 32'd0);
    send_cmd(KindRead, 11'd4, 11'd0, 12'd0, 32'd0);
    send_cmd(KindFinish, 11'd0, 11'd0, 12'd0, 32'd0);
    drain();
  endtask

  task automatic test_saturation();
    cfg_write(RegAlpha, 64'hFFFF);
    cfg_write(RegBase, 64'hFFFF_FFF0);
    cfg_write(RegEps, 64'd0);
    send_cmd(KindLoad, 11'd0, 11'd0, 12'd0, 32'hFFFF_FFFF);
    send_cmd(KindStart, 11'd0, 11'd0, 12'd0, 32'd0);
    send_cmd(KindEdge, 11'd0, 11'd2, 12'd1, 32'd0);
    send_cmd(KindRead, 11'd2, 11'd0, 12'd0, 32'd0);
    send_cmd(KindFinish, 11'd0, 11'd0, 12'd0, 32'd0);
    cfg_write(RegAlpha, 64'd32768);
    cfg_write(RegEps, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(KindFinish, 11'd0, 11'd0, 12'd0, 32'd0);
    cfg_write(RegAlpha, 64'd0);
    send_cmd(KindEdge, 11'd0, 11'd3, 12'd1, 32'd0);
    drain();
  endtask

  task automatic test_count_extremes();
    cfg_write(RegNodes, 64'd0);
    send_cmd(KindRead, 11'd0, 11'd0, 12'd0, 32'd0);
    send_cmd(KindFinish, 11'd0, 11'd0, 12'd0, 32'd0);
    cfg_write(RegNodes, 64'hFFF);
    send_cmd(KindRead, 11'd2047, 11'd0, 12'd0, 32'd0);
    drain();
  endtask

  function automatic logic [10:0] pick_vertex();
    int unsigned cnt;
    cnt = vertices_in_use();
    if (cnt == 0) return 11'($urandom_range(0, 2047));
    return 11'($urandom_range(0, cnt - 1));
  endfunction

  task automatic test_random_passes();
    int unsigned sent, r, pause_at, steps;
    logic [63:0] eps;
    sent = 0;
    while (sent < RandItems) begin
      r = $urandom_range(0, 19);
      cfg_write(RegNodes, 64'((r == 0) ? 12'd2048 : (r == 1) ? 12'($urandom_range(0, 4095))
                                                  : 12'($urandom_range(1, 64))));
      r = $urandom_range(0, 5);
      cfg_write(RegAlpha, (r == 0) ? 64'd0 : (r == 1) ? 64'd32768 : (r == 2) ? 64'hFFFF
                                   : 64'($urandom_range(0, 32768)));
      cfg_write(RegBase, (r == 3) ? 64'hFFFF_FFFF : 64'($urandom));
      r = $urandom_range(0, 4);
      eps = (r == 0) ? 64'd0 : (r == 1) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom};
      if (r == 2) eps = eps >> $urandom_range(0, 63);
      cfg_write(RegEps, eps);
      rx_mode = $urandom_range(0, 3);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      steps = $urandom_range(30, 70);
      pause_at = $urandom_range(0, steps - 1);
      if ($urandom_range(0, 4) != 0) begin
        send_cmd(KindStart, pick_vertex(), pick_vertex(), 12'($urandom), $urandom);
        sent++;
      end
      for (int i = 0; i < steps; i++) begin
        if (i == pause_at) drain();
        r = $urandom_range(0, 99);
        if (r < 10) begin
          r = $urandom_range(0, 7);
          send_cmd(3'(r), 11'($urandom), 11'($urandom), 12'($urandom), $urandom);
          if (r <= KindRead) sent++;
        end else begin
          if (r < 25)
            send_cmd(KindLoad, pick_vertex(), 11'($urandom), 12'($urandom), $urandom);
          else if (r < 85)
            send_cmd(KindEdge, pick_vertex(), pick_vertex(),
                     ($urandom_range(0, 15) == 0) ? 12'($urandom)
                                                  : 12'($urandom_range(1, 16)), $urandom);
          else
            send_cmd(KindRead, pick_vertex(), 11'($urandom), 12'($urandom), $urandom);
          sent++;
        end
      end
      send_cmd(KindFinish, 11'($urandom), 11'($urandom), 12'($urandom), $urandom);
      send_cmd(KindRead, pick_vertex(), 11'($urandom), 12'($urandom), $urandom);
      sent += 2;
    end
    drain();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= KindLoad;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= RegAlpha;
    cfg_data_i    <= '0;
    damping      = 16'd27853;
    teleport     = 32'd78643;
    threshold    = 64'd1152921504607;
    vertex_total = 12'd2048;
    for (int i = 0; i < MaxNodes; i++) begin
      old_bank[i] = '0;
      new_bank[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_pass();
    test_bad_index();
    test_saturation();
    test_count_extremes();
    test_random_passes();
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("pagerank_push_iteration_core test passed");
    end else begin
      $display("pagerank_push_iteration_core test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
